[rtl/iev_pkg.sv]
// ----------------------------------------------------------------------------
// Input event queue package
// Shared types, codes and reset values for the input event queue.
// ----------------------------------------------------------------------------
package iev_pkg;

    // Navigation event codes as held in the queue.
    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_UP     = 3'd1,
        EV_DOWN   = 3'd2,
        EV_LEFT   = 3'd3,
        EV_RIGHT  = 3'd4,
        EV_SELECT = 3'd5,
        EV_BACK   = 3'd6,
        EV_HOLD   = 3'd7
    } t_event;

    // Commands carried by an input beat.
    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_POP    = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    // Configuration register indexes (byte address / 4).
    typedef enum logic [2:0] {
        REG_SOURCE_ENABLE = 3'd0,
        REG_CODE_UP       = 3'd1,
        REG_CODE_DOWN     = 3'd2,
        REG_CODE_LEFT     = 3'd3,
        REG_CODE_RIGHT    = 3'd4,
        REG_CODE_SELECT   = 3'd5,
        REG_CODE_BACK     = 3'd6
    } t_reg;

    // Bit positions in source_enable.
    localparam int SRC_BUTTON  = 0;
    localparam int SRC_ENCODER = 1;
    localparam int SRC_KEYPAD  = 2;

    // Configuration port geometry.
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    // Push slots in one update, in their fixed order.
    localparam int NUM_PUSH      = 6;
    localparam int SLOT_BTN_SEL  = 0;
    localparam int SLOT_BTN_HOLD = 1;
    localparam int SLOT_ENC_DIR  = 2;
    localparam int SLOT_ENC_SEL  = 3;
    localparam int SLOT_ENC_HOLD = 4;
    localparam int SLOT_KEY      = 5;

    // Default ring size.
    localparam int QUEUE_DEPTH_DEF = 8;

    // Reset values of the configuration registers.
    localparam logic [2:0] RST_SOURCE_ENABLE = 3'd7;
    localparam logic [7:0] RST_CODE_UP       = 8'd50;
    localparam logic [7:0] RST_CODE_DOWN     = 8'd56;
    localparam logic [7:0] RST_CODE_LEFT     = 8'd52;
    localparam logic [7:0] RST_CODE_RIGHT    = 8'd54;
    localparam logic [7:0] RST_CODE_SELECT   = 8'd35;
    localparam logic [7:0] RST_CODE_BACK     = 8'd42;

    // Keypad character that means no key is pressed.
    localparam logic [7:0] CHAR_NONE = 8'd0;

    // Configuration handed to the datapath.
    typedef struct packed {
        logic [2:0] source_enable;
        logic [7:0] code_up;
        logic [7:0] code_down;
        logic [7:0] code_left;
        logic [7:0] code_right;
        logic [7:0] code_select;
        logic [7:0] code_back;
    } t_cfg;

    // One decoded step: command plus the candidate pushes in order.
    typedef struct packed {
        logic [1:0]                cmd;
        logic [NUM_PUSH-1:0]       vld;
        logic [NUM_PUSH-1:0][2:0]  ev;
    } t_step;

endpackage

[rtl/iev_in_if.sv]
// ----------------------------------------------------------------------------
// Input event queue input channel
// Valid/ready channel that carries one update, pop or clear beat.
// ----------------------------------------------------------------------------
interface iev_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic              btn_clicked;
    logic              btn_held;
    logic signed [7:0] enc_delta;
    logic              enc_clicked;
    logic              enc_held;
    logic [7:0]        pad_char;

    modport source (
        output valid, cmd, btn_clicked, btn_held, enc_delta, enc_clicked, enc_held,
               pad_char,
        input  ready
    );
    modport sink (
        input  valid, cmd, btn_clicked, btn_held, enc_delta, enc_clicked, enc_held,
               pad_char,
        output ready
    );
endinterface

[rtl/iev_out_if.sv]
// ----------------------------------------------------------------------------
// Input event queue result channel
// Valid/ready channel that carries one result beat per input beat.
// ----------------------------------------------------------------------------
interface iev_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] popped_event;
    logic [2:0] front_event;
    logic       is_empty;

    modport source (
        output valid, popped_event, front_event, is_empty,
        input  ready
    );
    modport sink (
        input  valid, popped_event, front_event, is_empty,
        output ready
    );
endinterface

[rtl/iev_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Input event queue configuration registers
// APB-style register file for source enables and keypad key codes.
// ----------------------------------------------------------------------------
module iev_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [iev_pkg::CFG_AW-1:0] paddr,
    input  logic [iev_pkg::CFG_DW-1:0] pwdata,
    output logic [iev_pkg::CFG_DW-1:0] prdata,
    output logic                       pready,
    output iev_pkg::t_cfg              o_cfg
);

    iev_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [2:0]    reg_idx;

    // Registers are word aligned; the low address bits are ignored.
    assign reg_idx = paddr[iev_pkg::CFG_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_enable <= iev_pkg::RST_SOURCE_ENABLE;
            r_cfg.code_up       <= iev_pkg::RST_CODE_UP;
            r_cfg.code_down     <= iev_pkg::RST_CODE_DOWN;
            r_cfg.code_left     <= iev_pkg::RST_CODE_LEFT;
            r_cfg.code_right    <= iev_pkg::RST_CODE_RIGHT;
            r_cfg.code_select   <= iev_pkg::RST_CODE_SELECT;
            r_cfg.code_back     <= iev_pkg::RST_CODE_BACK;
        end else if (wr_en) begin
            unique case (iev_pkg::t_reg'(reg_idx))
                iev_pkg::REG_SOURCE_ENABLE: r_cfg.source_enable <= pwdata[2:0];
                iev_pkg::REG_CODE_UP:       r_cfg.code_up       <= pwdata[7:0];
                iev_pkg::REG_CODE_DOWN:     r_cfg.code_down     <= pwdata[7:0];
                iev_pkg::REG_CODE_LEFT:     r_cfg.code_left     <= pwdata[7:0];
                iev_pkg::REG_CODE_RIGHT:    r_cfg.code_right    <= pwdata[7:0];
                iev_pkg::REG_CODE_SELECT:   r_cfg.code_select   <= pwdata[7:0];
                iev_pkg::REG_CODE_BACK:     r_cfg.code_back     <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Read data mux; unmapped addresses read as zero.
    always_comb begin
        prdata = '0;
        unique case (iev_pkg::t_reg'(reg_idx))
            iev_pkg::REG_SOURCE_ENABLE: prdata = {{(iev_pkg::CFG_DW-3){1'b0}},
                                                  r_cfg.source_enable};
            iev_pkg::REG_CODE_UP:     prdata = {{(iev_pkg::CFG_DW-8){1'b0}}, r_cfg.code_up};
            iev_pkg::REG_CODE_DOWN:   prdata = {{(iev_pkg::CFG_DW-8){1'b0}}, r_cfg.code_down};
            iev_pkg::REG_CODE_LEFT:   prdata = {{(iev_pkg::CFG_DW-8){1'b0}}, r_cfg.code_left};
            iev_pkg::REG_CODE_RIGHT:  prdata = {{(iev_pkg::CFG_DW-8){1'b0}}, r_cfg.code_right};
            iev_pkg::REG_CODE_SELECT: prdata = {{(iev_pkg::CFG_DW-8){1'b0}},
                                                r_cfg.code_select};
            iev_pkg::REG_CODE_BACK:   prdata = {{(iev_pkg::CFG_DW-8){1'b0}}, r_cfg.code_back};
            default:                  prdata = '0;
        endcase
    end

endmodule

[rtl/iev_event_gen.sv]
// ----------------------------------------------------------------------------
// Input event queue event generator
// Turns one input beat into up to six ordered candidate pushes.
// ----------------------------------------------------------------------------
module iev_event_gen (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_acc,
    input  iev_pkg::t_cfg     i_cfg,
    input  logic [1:0]        i_cmd,
    input  logic              i_btn_clicked,
    input  logic              i_btn_held,
    input  logic signed [7:0] i_enc_delta,
    input  logic              i_enc_clicked,
    input  logic              i_enc_held,
    input  logic [7:0]        i_pad_char,
    output iev_pkg::t_step    o_step
);

    logic [7:0]       r_prev_char;
    iev_pkg::t_event  key_ev;
    logic             btn_en;
    logic             enc_en;
    logic             pad_en;
    logic             key_new;

    assign btn_en  = i_cfg.source_enable[iev_pkg::SRC_BUTTON];
    assign enc_en  = i_cfg.source_enable[iev_pkg::SRC_ENCODER];
    assign pad_en  = i_cfg.source_enable[iev_pkg::SRC_KEYPAD];
    assign key_new = (i_pad_char != iev_pkg::CHAR_NONE) && (i_pad_char != r_prev_char);

    // Key mapping; the first matching code wins.
    always_comb begin
        if (i_pad_char == i_cfg.code_up) begin
            key_ev = iev_pkg::EV_UP;
        end else if (i_pad_char == i_cfg.code_down) begin
            key_ev = iev_pkg::EV_DOWN;
        end else if (i_pad_char == i_cfg.code_left) begin
            key_ev = iev_pkg::EV_LEFT;
        end else if (i_pad_char == i_cfg.code_right) begin
            key_ev = iev_pkg::EV_RIGHT;
        end else if (i_pad_char == i_cfg.code_select) begin
            key_ev = iev_pkg::EV_SELECT;
        end else if (i_pad_char == i_cfg.code_back) begin
            key_ev = iev_pkg::EV_BACK;
        end else begin
            key_ev = iev_pkg::EV_NONE;
        end
    end

    // Candidate pushes in their fixed order.
    always_comb begin
        o_step.cmd = i_cmd;

        o_step.ev[iev_pkg::SLOT_BTN_SEL]  = iev_pkg::EV_SELECT;
        o_step.vld[iev_pkg::SLOT_BTN_SEL] = btn_en && i_btn_clicked;

        o_step.ev[iev_pkg::SLOT_BTN_HOLD]  = iev_pkg::EV_HOLD;
        o_step.vld[iev_pkg::SLOT_BTN_HOLD] = btn_en && i_btn_held;

        // A negative delta is up, a positive one down, zero gives nothing.
        o_step.ev[iev_pkg::SLOT_ENC_DIR]  = i_enc_delta[7] ? iev_pkg::EV_UP : iev_pkg::EV_DOWN;
        o_step.vld[iev_pkg::SLOT_ENC_DIR] = enc_en && (i_enc_delta != 8'sd0);

        o_step.ev[iev_pkg::SLOT_ENC_SEL]  = iev_pkg::EV_SELECT;
        o_step.vld[iev_pkg::SLOT_ENC_SEL] = enc_en && i_enc_clicked;

        o_step.ev[iev_pkg::SLOT_ENC_HOLD]  = iev_pkg::EV_HOLD;
        o_step.vld[iev_pkg::SLOT_ENC_HOLD] = enc_en && i_enc_held;

        o_step.ev[iev_pkg::SLOT_KEY]  = key_ev;
        o_step.vld[iev_pkg::SLOT_KEY] = pad_en && key_new && (key_ev != iev_pkg::EV_NONE);
    end

    // The last key is tracked only on updates with the keypad enabled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_char <= iev_pkg::CHAR_NONE;
        end else if (i_acc && (iev_pkg::t_cmd'(i_cmd) == iev_pkg::CMD_UPDATE) && pad_en) begin
            r_prev_char <= i_pad_char;
        end
    end

endmodule

[rtl/iev_ring.sv]
// ----------------------------------------------------------------------------
// Input event queue ring
// Overwriting ring of events, pointer update for one step and result register.
// ----------------------------------------------------------------------------
module iev_ring #(
    parameter int QUEUE_DEPTH = iev_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  iev_pkg::t_step i_step,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [2:0]     o_popped_event,
    output logic [2:0]     o_front_event,
    output logic           o_is_empty
);

    localparam int              PW   = $clog2(QUEUE_DEPTH);
    localparam logic [PW-1:0]   LAST = PW'(QUEUE_DEPTH - 1);

    logic [2:0]    r_store [QUEUE_DEPTH];
    logic [2:0]    n_store [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW-1:0] n_wp;
    logic [PW-1:0] n_rp;
    logic          r_out_vld;
    logic [2:0]    r_popped;
    logic [2:0]    r_front;
    logic          r_empty;
    logic [2:0]    n_popped;
    logic [2:0]    n_front;
    logic          n_empty;
    logic          acc;

    logic [PW-1:0]       waddr [iev_pkg::NUM_PUSH];
    logic [iev_pkg::NUM_PUSH-1:0] wen;

    function automatic logic [PW-1:0] incr(input logic [PW-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    // A new beat is taken whenever the result register is free or draining.
    assign o_in_ready = !r_out_vld || i_out_ready;
    assign acc        = i_in_valid && o_in_ready;

    // Pointer walk over the pushes of one update, or a pop or a clear.
    always_comb begin
        logic [PW-1:0] wp;
        logic [PW-1:0] rp;
        logic [PW-1:0] nxt;
        wp       = r_wp;
        rp       = r_rp;
        nxt      = '0;
        wen      = '0;
        n_popped = iev_pkg::EV_NONE;
        for (int i = 0; i < iev_pkg::NUM_PUSH; i++) begin
            waddr[i] = '0;
        end
        if (acc) begin
            case (iev_pkg::t_cmd'(i_step.cmd))
                iev_pkg::CMD_UPDATE: begin
                    for (int i = 0; i < iev_pkg::NUM_PUSH; i++) begin
                        waddr[i] = wp;
                        if (i_step.vld[i]) begin
                            nxt = incr(wp);
                            // A full ring loses its oldest event.
                            if (nxt == rp) begin
                                rp = incr(rp);
                            end
                            wen[i] = 1'b1;
                            wp     = nxt;
                        end
                    end
                end
                iev_pkg::CMD_POP: begin
                    if (wp != rp) begin
                        n_popped = r_store[rp];
                        rp       = incr(rp);
                    end
                end
                iev_pkg::CMD_CLEAR: begin
                    wp = '0;
                    rp = '0;
                end
                default: begin
                end
            endcase
        end
        n_wp = wp;
        n_rp = rp;
    end

    // Per-entry write select; a later push into the same slot wins.
    always_comb begin
        for (int e = 0; e < QUEUE_DEPTH; e++) begin
            n_store[e] = r_store[e];
            for (int i = 0; i < iev_pkg::NUM_PUSH; i++) begin
                if (wen[i] && (waddr[i] == PW'(e))) begin
                    n_store[e] = i_step.ev[i];
                end
            end
        end
    end

    // Queue status after the step.
    assign n_empty = (n_wp == n_rp);
    assign n_front = n_empty ? iev_pkg::EV_NONE : n_store[n_rp];

    // Event store; entries are only read once written.
    always_ff @(posedge i_clk) begin
        for (int e = 0; e < QUEUE_DEPTH; e++) begin
            r_store[e] <= n_store[e];
        end
    end

    // Pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (acc) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_popped <= n_popped;
            r_front  <= n_front;
            r_empty  <= n_empty;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_popped_event = r_popped;
    assign o_front_event  = r_front;
    assign o_is_empty     = r_empty;

    // The reported empty flag agrees with the pointers it was taken from.
    a_empty_matches_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> (r_empty == (r_wp == r_rp)))
        else $error("empty flag disagrees with the ring pointers");

    // Only a pop can report a removed event.
    a_popped_only_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (iev_pkg::t_cmd'(i_step.cmd) != iev_pkg::CMD_POP))
        |=> (r_popped == iev_pkg::EV_NONE))
        else $error("event reported as popped on a step that was not a pop");

    // A clear leaves an empty ring with both pointers at the origin.
    a_clear_resets_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (iev_pkg::t_cmd'(i_step.cmd) == iev_pkg::CMD_CLEAR))
        |=> (r_wp == '0 && r_rp == '0 && r_empty))
        else $error("clear did not empty the ring");

    // An update that pushes anything leaves a non-empty ring.
    a_push_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (iev_pkg::t_cmd'(i_step.cmd) == iev_pkg::CMD_UPDATE) && (i_step.vld != '0))
        |=> (!r_empty && r_front != iev_pkg::EV_NONE))
        else $error("ring empty after a push");

endmodule

[rtl/input_event_queue_top.sv]
// ----------------------------------------------------------------------------
// Input event queue top level
// Merges button, encoder and keypad reports into a ring of navigation events.
// ----------------------------------------------------------------------------
// One beat is accepted in every clock cycle while results are taken, and its
// result beat appears in the result register on the following cycle; the
// input is ready whenever that register is empty or being taken in the same
// cycle. The rate rests on the ring update, which places all six possible
// pushes of an update in one pass through the pointer logic. The ring keeps
// QUEUE_DEPTH-1 events and a push into a full ring discards the oldest one.
// Reset needs no clearing pass: the queue starts empty and is usable at once.
module input_event_queue_top #(
    parameter int QUEUE_DEPTH = iev_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    iev_in_if.sink                     i_in,
    iev_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [iev_pkg::CFG_AW-1:0] paddr,
    input  logic [iev_pkg::CFG_DW-1:0] pwdata,
    output logic [iev_pkg::CFG_DW-1:0] prdata,
    output logic                       pready
);

    iev_pkg::t_cfg  cfg;
    iev_pkg::t_step step;
    logic           in_ready;
    logic           acc;

    assign i_in.ready = in_ready;
    assign acc        = i_in.valid && in_ready;

    // Configuration registers.
    iev_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Candidate events from the input beat.
    iev_event_gen u_gen (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (acc),
        .i_cfg         (cfg),
        .i_cmd         (i_in.cmd),
        .i_btn_clicked (i_in.btn_clicked),
        .i_btn_held    (i_in.btn_held),
        .i_enc_delta   (i_in.enc_delta),
        .i_enc_clicked (i_in.enc_clicked),
        .i_enc_held    (i_in.enc_held),
        .i_pad_char    (i_in.pad_char),
        .o_step        (step)
    );

    // Ring and result register.
    iev_ring #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in.valid),
        .o_in_ready     (in_ready),
        .i_step         (step),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_popped_event (o_out.popped_event),
        .o_front_event  (o_out.front_event),
        .o_is_empty     (o_out.is_empty)
    );

endmodule
